### sv/wto_pkg.sv
// Shared constants, codes and handshake types of the wavetable oscillator.
package wto_pkg;

    // Default geometry of the oscillator
    localparam int DEF_TABLE_SIZE      = 1024;
    localparam int DEF_PHASE_FRAC_BITS = 16;
    localparam int DEF_SAMPLE_BITS     = 16;

    // Fixed field widths
    localparam int FREQ_BITS        = 24;
    localparam int STEP_SCALE_BITS  = 32;
    localparam int START_PHASE_BITS = 26;
    localparam int CFG_DATA_BITS    = 32;
    localparam int CFG_ADDR_BITS    = 2;

    // freq is in 1/256 Hz and step_scale is Q0.32, so the product carries 40 fraction bits
    localparam int INC_ALIGN_BITS = 40;

    // Register reset values
    localparam logic                       INTERPOLATE_RESET = 1'b1;
    localparam logic [STEP_SCALE_BITS-1:0] STEP_SCALE_RESET  = 32'd91625968;

    // Register indexes
    localparam logic [CFG_ADDR_BITS-1:0] CFG_INTERPOLATE = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_STEP_SCALE  = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_START_PHASE = 2'd2;

    // Item kinds
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Control of the item held in the input stage
    typedef struct packed {
        logic valid;
        logic cmd;
    } stage_ctrl_t;

endpackage

### sv/wto_front.sv
// Input stage: captures items and forms the signed phase increment of each tick.
module wto_front import wto_pkg::*; #(
    parameter int IDX_W       = 10,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int PHASE_W     = 26,
    parameter int FRAC_BITS   = DEF_PHASE_FRAC_BITS,
    parameter int DATA_W      = 56
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic                        s_tuser,
    input  logic [DATA_W-1:0]           s_tdata,
    input  logic [STEP_SCALE_BITS-1:0]  step_scale,
    input  logic                        next_ready,
    output stage_ctrl_t                 ctrl,
    output logic [PHASE_W-1:0]          inc,
    output logic [IDX_W-1:0]            wr_index,
    output logic [SAMPLE_BITS-1:0]      wr_value
);

    localparam int PROD_W    = FREQ_BITS + STEP_SCALE_BITS + 1;
    localparam int INC_SHIFT = INC_ALIGN_BITS - FRAC_BITS;

    logic                         valid_reg;
    logic                         cmd_reg;
    logic [PHASE_W-1:0]           inc_reg;
    logic [IDX_W-1:0]             index_reg;
    logic [SAMPLE_BITS-1:0]       value_reg;

    logic signed [FREQ_BITS-1:0]       freq_s;
    logic signed [STEP_SCALE_BITS:0]   scale_s;
    logic signed [PROD_W-1:0]          prod;

    assign s_tready = !valid_reg || next_ready;

    assign freq_s  = $signed(s_tdata[FREQ_BITS-1:0]);
    assign scale_s = $signed({1'b0, step_scale});
    assign prod    = freq_s * scale_s;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    // Keep only the increment bits that survive the wrap of the phase
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            cmd_reg   <= s_tuser;
            inc_reg   <= prod[INC_SHIFT +: PHASE_W];
            index_reg <= s_tdata[FREQ_BITS +: IDX_W];
            value_reg <= s_tdata[FREQ_BITS + IDX_W +: SAMPLE_BITS];
        end
    end

    assign ctrl.valid = valid_reg;
    assign ctrl.cmd   = cmd_reg;
    assign inc        = inc_reg;
    assign wr_index   = index_reg;
    assign wr_value   = value_reg;

endmodule

### sv/wto_lookup.sv
// Phase accumulator and wave table memory with two registered read ports.
module wto_lookup import wto_pkg::*; #(
    parameter int TABLE_SIZE  = DEF_TABLE_SIZE,
    parameter int IDX_W       = 10,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int FRAC_BITS   = DEF_PHASE_FRAC_BITS,
    parameter int PHASE_W     = 26
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  stage_ctrl_t                 ctrl,
    input  logic [PHASE_W-1:0]          inc,
    input  logic [IDX_W-1:0]            wr_index,
    input  logic [SAMPLE_BITS-1:0]      wr_value,
    output logic                        ready,
    input  logic                        interpolate,
    input  logic                        phase_load,
    input  logic [PHASE_W-1:0]          phase_value,
    input  logic                        next_ready,
    output logic                        rd_valid,
    output logic [SAMPLE_BITS-1:0]      rd_a,
    output logic [SAMPLE_BITS-1:0]      rd_b,
    output logic [FRAC_BITS-1:0]        rd_frac
);

    logic [SAMPLE_BITS-1:0] wave_mem [TABLE_SIZE];

    logic [PHASE_W-1:0]     phase_acc_reg;
    logic                   valid_reg;
    logic [SAMPLE_BITS-1:0] a_reg;
    logic [SAMPLE_BITS-1:0] b_reg;
    logic [FRAC_BITS-1:0]   frac_reg;

    logic [IDX_W-1:0]       base_idx;
    logic [IDX_W-1:0]       next_idx;
    logic                   tick_adv;
    logic                   write_adv;

    assign ready     = !valid_reg || next_ready;
    assign tick_adv  = ctrl.valid && (ctrl.cmd == CMD_TICK) && ready;
    assign write_adv = ctrl.valid && (ctrl.cmd == CMD_WRITE) && ready;

    // Next entry wraps to entry 0 through the index width
    assign base_idx = phase_acc_reg[PHASE_W-1:FRAC_BITS];
    assign next_idx = base_idx + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_acc_reg <= '0;
        end else if (phase_load) begin
            phase_acc_reg <= phase_value;
        end else if (tick_adv) begin
            phase_acc_reg <= phase_acc_reg + inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (write_adv) begin
            wave_mem[wr_index] <= wr_value;
        end
        if (ready) begin
            a_reg <= wave_mem[base_idx];
            b_reg <= wave_mem[next_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ready) begin
            valid_reg <= tick_adv;
        end
    end

    // A zero fraction turns the blend into a plain lookup
    always_ff @(posedge aclk) begin
        if (ready) begin
            frac_reg <= interpolate ? phase_acc_reg[FRAC_BITS-1:0] : '0;
        end
    end

    assign rd_valid = valid_reg;
    assign rd_a     = a_reg;
    assign rd_b     = b_reg;
    assign rd_frac  = frac_reg;

    a_tick_reaches_read: assert property (@(posedge aclk) disable iff (!aresetn)
        tick_adv |=> valid_reg)
        else $error("tick transfer did not reach the read stage");

    a_write_gives_no_read: assert property (@(posedge aclk) disable iff (!aresetn)
        write_adv |=> !valid_reg)
        else $error("table write produced a read stage item");

    a_phase_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (!tick_adv && !phase_load) |=> $stable(phase_acc_reg))
        else $error("phase moved without a tick or a load");

endmodule

### sv/wto_interp.sv
// Linear blend of two neighboring entries and the output register.
module wto_interp import wto_pkg::*; #(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int FRAC_BITS   = DEF_PHASE_FRAC_BITS,
    parameter int OUT_W       = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    rd_valid,
    input  logic [SAMPLE_BITS-1:0]  rd_a,
    input  logic [SAMPLE_BITS-1:0]  rd_b,
    input  logic [FRAC_BITS-1:0]    rd_frac,
    output logic                    ready,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [OUT_W-1:0]        m_tdata
);

    localparam int PROD_W = SAMPLE_BITS + FRAC_BITS + 2;

    logic                     valid_reg;
    logic [SAMPLE_BITS-1:0]   a_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     out_valid_reg;
    logic [SAMPLE_BITS-1:0]   sample_reg;

    logic                          out_ready;
    logic signed [SAMPLE_BITS:0]   diff;
    logic signed [FRAC_BITS:0]     frac_s;
    logic signed [PROD_W-1:0]      prod_next;
    logic signed [PROD_W-1:0]      step;
    logic [SAMPLE_BITS-1:0]        sample_next;

    assign out_ready = !out_valid_reg || m_tready;
    assign ready     = !valid_reg || out_ready;

    assign diff      = $signed({rd_b[SAMPLE_BITS-1], rd_b}) - $signed({rd_a[SAMPLE_BITS-1], rd_a});
    assign frac_s    = $signed({1'b0, rd_frac});
    // Force zero so an entry past the lookup never leaks into a truncated sample
    assign prod_next = (rd_frac == '0) ? $signed({PROD_W{1'b0}}) : diff * frac_s;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ready) begin
            valid_reg <= rd_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready) begin
            a_reg    <= rd_a;
            prod_reg <= prod_next;
        end
    end

    // The blend stays between the two entries, so a wrapping add is exact
    assign step        = prod_reg >>> FRAC_BITS;
    assign sample_next = a_reg + step[SAMPLE_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (valid_reg && out_ready) begin
            sample_reg <= sample_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'(sample_reg);

endmodule

### sv/wavetable_oscillator.sv
// Wavetable oscillator: a phase accumulator reads a wave table, optionally interpolating.
//
// Input channel s_*: each transfer carries one item. s_tuser selects the kind:
// a table write stores one entry and gives no result, a tick gives one sample
// read at the current phase, after which the phase advances by freq * step_scale.
// Output channel m_*: one sample transfer per tick, in the order of the ticks.
// Configuration: cfg_we writes cfg_wdata to the register cfg_addr at that edge
// (0 interpolate, 1 step_scale, 2 start_phase, which also loads the phase).
// Configure only while no item is in flight.
// Throughput: one item per cycle while m_tready does not stall the output. A tick
// passes the increment multiply, table read, blend multiply and output register,
// in that order, before its sample shows on m_tvalid. The table memory's registered
// read sets the second step.
// Reset clears the pipeline, loads the register reset values and sets the phase
// to zero; table contents stay undefined until written. When m_tready is low the
// sample holds and items keep entering until every stage is full, then s_tready
// drops.
module wavetable_oscillator import wto_pkg::*; #(
    parameter int TABLE_SIZE      = DEF_TABLE_SIZE,
    parameter int PHASE_FRAC_BITS = DEF_PHASE_FRAC_BITS,
    parameter int SAMPLE_BITS     = DEF_SAMPLE_BITS,
    localparam int IDX_W          = $clog2(TABLE_SIZE),
    localparam int PHASE_W        = IDX_W + PHASE_FRAC_BITS,
    localparam int IN_DATA_W      = ((FREQ_BITS + IDX_W + SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_DATA_W     = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic                      s_tuser,   // cmd
    input  logic [IN_DATA_W-1:0]      s_tdata,   // freq, table_index, table_value, zero pad
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [OUT_DATA_W-1:0]     m_tdata,   // sample, zero pad
    input  logic                      cfg_we,
    input  logic [CFG_ADDR_BITS-1:0]  cfg_addr,
    input  logic [CFG_DATA_BITS-1:0]  cfg_wdata
);

    logic                        interpolate_reg;
    logic [STEP_SCALE_BITS-1:0]  step_scale_reg;

    logic                        phase_load;
    logic [PHASE_W-1:0]          phase_value;

    stage_ctrl_t                 front_ctrl;
    logic [PHASE_W-1:0]          front_inc;
    logic [IDX_W-1:0]            front_index;
    logic [SAMPLE_BITS-1:0]      front_value;
    logic                        lookup_ready;

    logic                        rd_valid;
    logic [SAMPLE_BITS-1:0]      rd_a;
    logic [SAMPLE_BITS-1:0]      rd_b;
    logic [PHASE_FRAC_BITS-1:0]  rd_frac;
    logic                        interp_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interpolate_reg <= INTERPOLATE_RESET;
            step_scale_reg  <= STEP_SCALE_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_INTERPOLATE: interpolate_reg <= cfg_wdata[0];
                CFG_STEP_SCALE:  step_scale_reg  <= cfg_wdata[STEP_SCALE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Mask the start phase to the phase width
    assign phase_load  = cfg_we && (cfg_addr == CFG_START_PHASE);
    assign phase_value = PHASE_W'(cfg_wdata[START_PHASE_BITS-1:0]);

    wto_front #(
        .IDX_W       (IDX_W),
        .SAMPLE_BITS (SAMPLE_BITS),
        .PHASE_W     (PHASE_W),
        .FRAC_BITS   (PHASE_FRAC_BITS),
        .DATA_W      (IN_DATA_W)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .step_scale (step_scale_reg),
        .next_ready (lookup_ready),
        .ctrl       (front_ctrl),
        .inc        (front_inc),
        .wr_index   (front_index),
        .wr_value   (front_value)
    );

    wto_lookup #(
        .TABLE_SIZE  (TABLE_SIZE),
        .IDX_W       (IDX_W),
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (PHASE_FRAC_BITS),
        .PHASE_W     (PHASE_W)
    ) u_lookup (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (front_ctrl),
        .inc         (front_inc),
        .wr_index    (front_index),
        .wr_value    (front_value),
        .ready       (lookup_ready),
        .interpolate (interpolate_reg),
        .phase_load  (phase_load),
        .phase_value (phase_value),
        .next_ready  (interp_ready),
        .rd_valid    (rd_valid),
        .rd_a        (rd_a),
        .rd_b        (rd_b),
        .rd_frac     (rd_frac)
    );

    wto_interp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (PHASE_FRAC_BITS),
        .OUT_W       (OUT_DATA_W)
    ) u_interp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_valid (rd_valid),
        .rd_a     (rd_a),
        .rd_b     (rd_b),
        .rd_frac  (rd_frac),
        .ready    (interp_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

### tb/wavetable_oscillator_chk.sv
// Stream checker for the wavetable oscillator: tracks phase and table, predicts each sample.
`timescale 1ns / 100ps

module wavetable_oscillator_chk import wto_pkg::*; #(
    localparam int IDX_W  = $clog2(DEF_TABLE_SIZE),
    localparam int FRAC_W = DEF_PHASE_FRAC_BITS,
    localparam int SMP_W  = DEF_SAMPLE_BITS,
    localparam int PHASE_W = IDX_W + FRAC_W,
    localparam int IN_W   = ((FREQ_BITS + IDX_W + SMP_W + 7) / 8) * 8,
    localparam int OUT_W  = ((SMP_W + 7) / 8) * 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    input  logic                     s_tready,
    input  logic                     s_tuser,   // cmd
    input  logic [IN_W-1:0]          s_tdata,   // freq, table_index, table_value, zero pad
    input  logic                     m_tvalid,
    input  logic                     m_tready,
    input  logic [OUT_W-1:0]         m_tdata,   // sample
    input  logic                     cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
    output int                       mismatches,
    output int                       samples_due
);

    logic                       interp_on;
    logic [STEP_SCALE_BITS-1:0] step_scale;
    logic [PHASE_W-1:0]         phase;
    logic signed [SMP_W-1:0]    wave_mem [0:DEF_TABLE_SIZE-1];
    logic [SMP_W-1:0]           expected_samples [$];

    // Sample at the current phase, truncated or blended with the next entry
    function automatic logic [SMP_W-1:0] predict_sample();
        logic [IDX_W-1:0] base;
        logic [IDX_W-1:0] nxt;
        longint           a;
        longint           b;
        longint           frac;
        longint           v;
        base = phase[PHASE_W-1:FRAC_W];
        nxt  = base + 1'b1;
        frac = longint'(phase[FRAC_W-1:0]);
        a    = wave_mem[base];
        v    = a;
        if (interp_on) begin
            b = wave_mem[nxt];
            v = a + (((b - a) * frac) >>> FRAC_W);
        end
        return v[SMP_W-1:0];
    endfunction

    // Phase after one tick; the increment is floored, then wrapped to the phase width
    function automatic logic [PHASE_W-1:0] advance_phase(logic signed [FREQ_BITS-1:0] f);
        longint prod;
        longint inc;
        prod = longint'(f) * longint'({32'b0, step_scale});
        inc  = prod >>> (INC_ALIGN_BITS - FRAC_W);
        return phase + inc[PHASE_W-1:0];
    endfunction

    always @(posedge aclk) begin
        logic [SMP_W-1:0] want;
        if (!aresetn) begin
            interp_on  = INTERPOLATE_RESET;
            step_scale = STEP_SCALE_RESET;
            phase      = '0;
            mismatches = 0;
            expected_samples.delete();
        end else begin
            // retire the oldest expectation before this edge's input can add one
            if (m_tvalid && m_tready) begin
                if (expected_samples.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected sample transfer: got %0d",
                                 $signed(m_tdata[SMP_W-1:0]));
                end else begin
                    want = expected_samples.pop_front();
                    if (m_tdata[SMP_W-1:0] !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("sample mismatch: expected %0d, got %0d",
                                     $signed(want), $signed(m_tdata[SMP_W-1:0]));
                    end
                end
            end
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_INTERPOLATE: interp_on  = cfg_wdata[0];
                    CFG_STEP_SCALE:  step_scale = cfg_wdata[STEP_SCALE_BITS-1:0];
                    CFG_START_PHASE: phase      = cfg_wdata[PHASE_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == CMD_WRITE) begin
                    wave_mem[s_tdata[FREQ_BITS +: IDX_W]] = s_tdata[FREQ_BITS+IDX_W +: SMP_W];
                end else begin
                    expected_samples.push_back(predict_sample());
                    phase = advance_phase(s_tdata[FREQ_BITS-1:0]);
                end
            end
        end
        samples_due <= expected_samples.size();
    end

endmodule

### tb/wavetable_oscillator_tb.sv
// Testbench top for the wavetable oscillator: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 100ps

module wavetable_oscillator_tb;
    import wto_pkg::*;

    localparam int IDX_W     = $clog2(DEF_TABLE_SIZE);
    localparam int SMP_W     = DEF_SAMPLE_BITS;
    localparam int IN_W      = ((FREQ_BITS + IDX_W + SMP_W + 7) / 8) * 8;
    localparam int OUT_W     = ((SMP_W + 7) / 8) * 8;
    localparam int TABLE_LEN = DEF_TABLE_SIZE;

    localparam logic [CFG_ADDR_BITS-1:0] CFG_NO_REG = 2'd3;

    localparam int PHASE_ITEMS    = 135;
    localparam int LONG_HOLD      = 120;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic [FREQ_BITS-1:0] FREQ_MAX = 24'h7F_FFFF;
    localparam logic [FREQ_BITS-1:0] FREQ_MIN = 24'h80_0000;

    logic                     aclk;
    logic                     aresetn   = 1'b0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic                     s_tuser   = CMD_TICK;
    logic [IN_W-1:0]          s_tdata   = '0;   // freq, table_index, table_value, zero pad
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic [OUT_W-1:0]         m_tdata;          // sample
    logic                     cfg_we    = 1'b0;
    logic [CFG_ADDR_BITS-1:0] cfg_addr  = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

    int mismatches;
    int samples_due;

    bit idle_on   = 1'b1;
    bit hold_req  = 1'b0;
    bit hold_done = 1'b0;

    wavetable_oscillator u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    wavetable_oscillator_chk u_chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tuser     (s_tuser),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .samples_due (samples_due)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Offer one item and hold it until the transfer
    task automatic send_item(input logic cmd, input logic [FREQ_BITS-1:0] frq,
                             input logic [IDX_W-1:0] idx, input logic [SMP_W-1:0] val);
        logic [IN_W-1:0] word;
        word = '0;
        word[FREQ_BITS-1:0]              = frq;
        word[FREQ_BITS +: IDX_W]         = idx;
        word[FREQ_BITS+IDX_W +: SMP_W]   = val;
        if (idle_on && $urandom_range(0, 9) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= word;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_tick(input logic [FREQ_BITS-1:0] frq);
        send_item(CMD_TICK, frq, IDX_W'($urandom_range(0, TABLE_LEN - 1)), SMP_W'($urandom));
    endtask

    task automatic send_write(input logic [IDX_W-1:0] idx, input logic [SMP_W-1:0] val);
        send_item(CMD_WRITE, FREQ_BITS'($urandom), idx, val);
    endtask

    task automatic send_random();
        int               pick;
        logic [FREQ_BITS-1:0] frq;
        pick = $urandom_range(0, 9);
        if ($urandom_range(0, 4) == 0) begin
            send_write(IDX_W'($urandom_range(0, TABLE_LEN - 1)), SMP_W'($urandom));
        end else begin
            if (pick == 0)
                frq = $urandom_range(0, 1) ? FREQ_MAX : FREQ_MIN;
            else if (pick <= 3)
                frq = FREQ_BITS'($urandom_range(0, 128) - 64);
            else
                frq = FREQ_BITS'($urandom);
            send_tick(frq);
        end
    endtask

    // Drop valid, wait for every sample and for write items still in the pipeline
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (samples_due != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_ADDR_BITS-1:0] addr,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // Receiver: random stall bursts, one long hold-off on request
    initial begin
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Watchdog: end the run after too many cycles without any transfer
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Load every entry so no tick ever reads an unwritten one
        for (int i = 0; i < TABLE_LEN; i++)
            send_write(IDX_W'(i), SMP_W'($urandom));

        // Full-scale neighbors, including the wrap from the last entry to entry 0
        send_write(IDX_W'(0), 16'h8000);
        send_write(IDX_W'(1), 16'h7FFF);
        send_write(IDX_W'(TABLE_LEN - 1), 16'h7FFF);
        send_tick('0);
        settle();
        cfg_write(CFG_START_PHASE, 32'h0000_8000);
        send_tick('0);
        settle();
        // bits above the phase width must be dropped
        cfg_write(CFG_START_PHASE, 32'hFFFF_FFFF);
        send_tick(24'd1);
        send_tick(24'hFF_FFFF);
        send_tick(FREQ_MAX);
        send_tick(FREQ_MIN);
        send_write(IDX_W'(TABLE_LEN / 2), 16'h0000);
        send_write(IDX_W'(TABLE_LEN / 2 + 1), 16'hFFFF);
        send_tick('0);
        settle();
        cfg_write(CFG_INTERPOLATE, 32'd0);
        cfg_write(CFG_STEP_SCALE, 32'hFFFF_FFFF);
        send_tick(FREQ_MIN);
        send_tick(FREQ_MAX);
        send_tick(24'h00_0100);
        send_tick('0);
        settle();
        cfg_write(CFG_NO_REG, 32'hFFFF_FFFF);
        cfg_write(CFG_STEP_SCALE, '0);
        send_tick(24'h12_3456);
        send_tick(FREQ_MIN);

        for (int p = 0; p < 6; p++) begin
            settle();
            idle_on = (p != 3) && (p != 5);
            case (p)
                0: begin
                    cfg_write(CFG_INTERPOLATE, 32'd1);
                    cfg_write(CFG_STEP_SCALE, STEP_SCALE_RESET);
                    cfg_write(CFG_START_PHASE, $urandom);
                end
                1: begin
                    cfg_write(CFG_INTERPOLATE, 32'd0);
                    cfg_write(CFG_STEP_SCALE, $urandom);
                    cfg_write(CFG_START_PHASE, $urandom_range(0, 32'h03FF_FFFF));
                end
                2: begin
                    cfg_write(CFG_INTERPOLATE, 32'd1);
                    cfg_write(CFG_STEP_SCALE, 32'hFFFF_FFFF);
                    cfg_write(CFG_START_PHASE, '0);
                    hold_req = 1'b1;
                end
                3: begin
                    cfg_write(CFG_INTERPOLATE, 32'd0);
                    cfg_write(CFG_STEP_SCALE, '0);
                    cfg_write(CFG_START_PHASE, 32'h03FF_FFFF);
                end
                4: begin
                    // slow sweep keeps the fraction busy between neighbors
                    cfg_write(CFG_INTERPOLATE, 32'd1);
                    cfg_write(CFG_STEP_SCALE, $urandom_range(0, 32'h00FF_FFFF));
                    cfg_write(CFG_START_PHASE, $urandom);
                end
                default: begin
                    cfg_write(CFG_INTERPOLATE, 32'd1);
                    cfg_write(CFG_STEP_SCALE, STEP_SCALE_RESET);
                    cfg_write(CFG_START_PHASE, '0);
                end
            endcase
            repeat (PHASE_ITEMS) send_random();
        end

        settle();
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
